@@ rtl/core/packet_assembly_fifo_overwrite_defines.svh @@
// assertion macros for the packet fifo with overwrite
// used by the control module; no other dependencies
`ifndef PACKET_ASSEMBLY_FIFO_OVERWRITE_DEFINES_SVH
`define PACKET_ASSEMBLY_FIFO_OVERWRITE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PAFO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pafo: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PAFO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pafo: next-cycle check failed");

`endif

@@ rtl/core/pafo_pkg.sv @@
// shared types and constants for the packet fifo with overwrite
// no dependencies
`timescale 1ns / 1ps

package pafo_pkg;

  localparam int unsigned SLOTS_DEF        = 16;
  localparam int unsigned PACKET_BYTES_DEF = 64;

  localparam int unsigned SIZE_W = 7;  // packet_size register and fill level
  localparam int unsigned CNT_W  = 5;  // slots_in_use register and stored count
  localparam int unsigned IDX_W  = 2;  // config register index
  localparam int unsigned BYTE_W = 8;

  localparam logic [IDX_W-1:0] CFG_PACKET_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PURGE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

@@ rtl/core/pafo_store.sv @@
// packet byte store: one write port, one read port with registered data
// depends on pafo_pkg
`timescale 1ns / 1ps

module pafo_store #(
  parameter int unsigned SLOTS        = pafo_pkg::SLOTS_DEF,
  parameter int unsigned PACKET_BYTES = pafo_pkg::PACKET_BYTES_DEF,
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned OFS_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1,
  localparam int unsigned ADDR_W = SLOT_W + OFS_W
) (
  input  logic                          clk_i,
  input  pafo_pkg::mem_ctl_t            ctl_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [pafo_pkg::BYTE_W-1:0]   wdata_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [pafo_pkg::BYTE_W-1:0]   rdata_o
);

  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic [pafo_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [pafo_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/pafo_ctrl.sv @@
// ring pointers, fill tracking, pop sequencer and result registers
// depends on pafo_pkg and packet_assembly_fifo_overwrite_defines.svh
`timescale 1ns / 1ps
`include "packet_assembly_fifo_overwrite_defines.svh"

module pafo_ctrl #(
  parameter int unsigned SLOTS        = pafo_pkg::SLOTS_DEF,
  parameter int unsigned PACKET_BYTES = pafo_pkg::PACKET_BYTES_DEF,
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned OFS_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1,
  localparam int unsigned ADDR_W = SLOT_W + OFS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic [pafo_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pafo_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [pafo_pkg::SIZE_W-1:0]   cfg_data_i,
  output pafo_pkg::mem_ctl_t            mem_ctl_o,
  output logic [ADDR_W-1:0]             mem_waddr_o,
  output logic [pafo_pkg::BYTE_W-1:0]   mem_wdata_o,
  output logic [ADDR_W-1:0]             mem_raddr_o,
  input  logic [pafo_pkg::BYTE_W-1:0]   mem_rdata_i,
  output logic                          result_valid_o,
  output logic [1:0]                    kind_o,
  output logic [pafo_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          last_o,
  output logic [pafo_pkg::CNT_W-1:0]    remain_o,
  output logic                          dropped_oldest_o
);

  localparam int unsigned SUM_W  = ((SLOT_W > pafo_pkg::CNT_W) ? SLOT_W : pafo_pkg::CNT_W) + 1;
  localparam int unsigned SW     = pafo_pkg::SIZE_W;
  localparam int unsigned CW     = pafo_pkg::CNT_W;

  // ring and fill state
  logic [SLOT_W-1:0]     oldest_q, oldest_d;
  logic [CW-1:0]         count_q, count_d;
  logic [SW-1:0]         fill_q, fill_d;
  logic                  drop_q, drop_d;
  // effective sizes, clamped at write time
  logic [SW-1:0]         psize_q, psize_d;
  logic [CW-1:0]         nslots_q, nslots_d;
  // pop sequencer
  logic                  stream_q, stream_d;
  logic [SLOT_W-1:0]     rd_slot_q, rd_slot_d;
  logic [SW-1:0]         idx_q, idx_d;
  // result registers
  logic                  res_vld_q, res_vld_d;
  pafo_pkg::kind_e       kind_q, kind_d;
  logic                  last_q, last_d;
  logic [CW-1:0]         remain_q, remain_d;
  logic                  dropped_q, dropped_d;

  logic                  acc;
  logic                  cfg_acc;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      inc;
  logic [SLOT_W-1:0]     wr_slot;
  logic [SLOT_W-1:0]     oldest_inc;
  logic                  need_drop;
  logic [SW-1:0]         fill_inc;
  logic [CW-1:0]         cnt_tmp;
  logic                  drop_tmp;
  logic                  byte_last;

  // a request on start_i holds register writes off
  assign acc         = start_i & ~stream_q;
  assign cfg_ready_o = ~stream_q & ~start_i;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign busy_o      = stream_q;

  // write slot sits just past the stored packets, wrapping once at most
  assign sum     = SUM_W'(oldest_q) + SUM_W'(count_q);
  assign wr_slot = (sum >= SUM_W'(nslots_q)) ? SLOT_W'(sum - SUM_W'(nslots_q))
                                             : SLOT_W'(sum);
  assign inc        = SUM_W'(oldest_q) + SUM_W'(1);
  assign oldest_inc = (inc == SUM_W'(nslots_q)) ? '0 : SLOT_W'(inc);

  assign need_drop = (fill_q == '0) && (count_q >= nslots_q);
  assign fill_inc  = fill_q + SW'(1);
  assign byte_last = (idx_q == psize_q - SW'(1));

  assign mem_waddr_o = {wr_slot, fill_q[OFS_W-1:0]};
  assign mem_wdata_o = data_byte_i;
  assign mem_raddr_o = {rd_slot_q, idx_q[OFS_W-1:0]};

  always_comb begin
    oldest_d   = oldest_q;
    count_d    = count_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    psize_d    = psize_q;
    nslots_d   = nslots_q;
    stream_d   = stream_q;
    rd_slot_d  = rd_slot_q;
    idx_d      = idx_q;
    res_vld_d  = 1'b0;
    kind_d     = kind_q;
    last_d     = 1'b0;
    remain_d   = remain_q;
    dropped_d  = 1'b0;
    mem_ctl_o  = '0;
    cnt_tmp    = count_q;
    drop_tmp   = drop_q;

    if (stream_q) begin
      mem_ctl_o.rd_en = 1'b1;
      res_vld_d       = 1'b1;
      kind_d          = pafo_pkg::KIND_BYTE;
      last_d          = byte_last;
      remain_d        = count_q;
      idx_d           = idx_q + SW'(1);
      if (byte_last) begin
        stream_d = 1'b0;
      end
    end else if (cfg_acc) begin
      // a write to packet_size or slots_in_use empties the fifo and restarts the ring
      if (cfg_index_i == pafo_pkg::CFG_PACKET_SIZE) begin
        if (cfg_data_i == '0) begin
          psize_d = SW'(1);
        end else if (cfg_data_i > SW'(PACKET_BYTES)) begin
          psize_d = SW'(PACKET_BYTES);
        end else begin
          psize_d = cfg_data_i;
        end
      end
      if (cfg_index_i == pafo_pkg::CFG_SLOTS_IN_USE) begin
        if (cfg_data_i[CW-1:0] == '0) begin
          nslots_d = CW'(1);
        end else if ({4'b0, cfg_data_i[CW-1:0]} > 9'(SLOTS)) begin
          nslots_d = CW'(SLOTS);
        end else begin
          nslots_d = cfg_data_i[CW-1:0];
        end
      end
      if (cfg_index_i == pafo_pkg::CFG_PACKET_SIZE ||
          cfg_index_i == pafo_pkg::CFG_SLOTS_IN_USE) begin
        oldest_d = '0;
        count_d  = '0;
        fill_d   = '0;
        drop_d   = 1'b0;
      end
    end else if (acc) begin
      unique case (mode_i)
        pafo_pkg::MODE_PUSH: begin
          mem_ctl_o.wr_en = 1'b1;
          if (need_drop) begin
            oldest_d = oldest_inc;
            cnt_tmp  = count_q - CW'(1);
            drop_tmp = 1'b1;
          end
          if (fill_inc == psize_q) begin
            fill_d    = '0;
            count_d   = cnt_tmp + CW'(1);
            drop_d    = 1'b0;
            res_vld_d = 1'b1;
            kind_d    = pafo_pkg::KIND_STORED;
            remain_d  = cnt_tmp + CW'(1);
            dropped_d = drop_tmp;
          end else begin
            fill_d  = fill_inc;
            count_d = cnt_tmp;
            drop_d  = drop_tmp;
          end
        end
        pafo_pkg::MODE_POP: begin
          if (count_q == '0) begin
            res_vld_d = 1'b1;
            kind_d    = pafo_pkg::KIND_EMPTY;
            remain_d  = '0;
          end else begin
            rd_slot_d = oldest_q;
            oldest_d  = oldest_inc;
            count_d   = count_q - CW'(1);
            stream_d  = 1'b1;
            idx_d     = '0;
          end
        end
        pafo_pkg::MODE_PURGE: begin
          oldest_d = wr_slot;
          count_d  = '0;
          fill_d   = '0;
          drop_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      fill_q    <= '0;
      drop_q    <= 1'b0;
      psize_q   <= SW'(PACKET_BYTES);
      nslots_q  <= (SLOTS > 16) ? CW'(16) : CW'(SLOTS);
      stream_q  <= 1'b0;
      rd_slot_q <= '0;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
      kind_q    <= pafo_pkg::KIND_STORED;
      last_q    <= 1'b0;
      remain_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      fill_q    <= fill_d;
      drop_q    <= drop_d;
      psize_q   <= psize_d;
      nslots_q  <= nslots_d;
      stream_q  <= stream_d;
      rd_slot_q <= rd_slot_d;
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
      kind_q    <= kind_d;
      last_q    <= last_d;
      remain_q  <= remain_d;
      dropped_q <= dropped_d;
    end
  end

  assign result_valid_o   = res_vld_q;
  assign kind_o           = kind_q;
  assign out_byte_o       = (kind_q == pafo_pkg::KIND_BYTE) ? mem_rdata_i : '0;
  assign last_o           = last_q;
  assign remain_o         = remain_q;
  assign dropped_oldest_o = dropped_q;

  `PAFO_ASSERT_NOW(a_count_bound, 1'b1, count_q <= nslots_q)
  `PAFO_ASSERT_NOW(a_fill_bound, 1'b1, fill_q < psize_q)
  `PAFO_ASSERT_NEXT(a_pop_streams, acc && !cfg_acc && mode_i == pafo_pkg::MODE_POP && count_q != '0, stream_q && idx_q == '0)
  `PAFO_ASSERT_NOW(a_last_ends, res_vld_q && last_q, !stream_q && kind_q == pafo_pkg::KIND_BYTE)

endmodule

@@ rtl/core/packet_assembly_fifo_overwrite.sv @@
// packet fifo with overwrite of the oldest packet, top level
// depends on pafo_pkg, pafo_ctrl and pafo_store
//
//   channel   handshake                 payload
//   command   start_i / busy_o          mode_i, data_byte_i
//   result    result_valid_o (strobe)   kind_o, out_byte_o, last_o, remain_o,
//                                       dropped_oldest_o
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// push, purge and an empty pop leave busy_o low; a store or empty result
// strobes the cycle after the request.
// a pop of a stored packet holds busy_o while it reads packet_size bytes, one store
// read per cycle; each byte strobes in the cycle after its read.
// reset clears the ring pointers and counts; store contents are not cleared.
// results cannot be stalled and strobe one cycle; start_i high holds cfg_ready_o low.
`timescale 1ns / 1ps

module packet_assembly_fifo_overwrite #(
  parameter int unsigned SLOTS        = pafo_pkg::SLOTS_DEF,
  parameter int unsigned PACKET_BYTES = pafo_pkg::PACKET_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic [pafo_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pafo_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [pafo_pkg::SIZE_W-1:0]   cfg_data_i,
  output logic                          result_valid_o,
  output logic [1:0]                    kind_o,
  output logic [pafo_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          last_o,
  output logic [pafo_pkg::CNT_W-1:0]    remain_o,
  output logic                          dropped_oldest_o
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OFS_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int unsigned ADDR_W = SLOT_W + OFS_W;

  pafo_pkg::mem_ctl_t           mem_ctl;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [pafo_pkg::BYTE_W-1:0]  mem_wdata;
  logic [pafo_pkg::BYTE_W-1:0]  mem_rdata;

  pafo_ctrl #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mem_ctl_o        (mem_ctl),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .result_valid_o   (result_valid_o),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .remain_o         (remain_o),
    .dropped_oldest_o (dropped_oldest_o)
  );

  pafo_store #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
